/* hdl/ptd_pkg.sv */
// shared types and constants for the periodic task dispatcher
`default_nettype none
package ptd_pkg;

  // table geometry
  localparam int MAX_TASKS = 16;
  localparam int KEY_BITS  = 8;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int WORD_W    = 32;

  // request codes
  typedef enum logic [2:0] {
    CMD_REGISTER     = 3'd0,
    CMD_SET_ENABLE   = 3'd1,
    CMD_SET_INTERVAL = 3'd2,
    CMD_TICK         = 3'd3,
    CMD_CLEAR        = 3'd4
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // control states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [WORD_W-1:0]   interval;
    logic                enable;
    logic [WORD_W-1:0]   last_run;
  } entry_t;

endpackage
`default_nettype wire

/* hdl/periodic_task_dispatcher.sv */
// periodic task dispatcher: task table in a single-port-read entry memory
`default_nettype none
// Keeps up to MAX_TASKS periodic tasks in registration order in one entry
// memory with a registered read. Register, set enable, set interval and tick
// walk the table one entry per cycle while the output is not stalled:
// register, set enable and set interval stop at the first matching key, a
// tick visits every stored entry (or stops at the first firing in priority
// mode). A new request is taken only when the block is idle again. A tick
// gives one result per firing in table order, or one plain result when
// nothing fires; every other request gives one result.
// The last result of a request has last set.
// The priority_mode register may be written at any time the block is idle.
module periodic_task_dispatcher
  import ptd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                priority_mode,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [2:0]          command,
  input  wire logic [KEY_BITS-1:0] task_key,
  input  wire logic [WORD_W-1:0]   interval_in,
  input  wire logic                enable_in,
  input  wire logic [WORD_W-1:0]   tick_now,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic                     fired,
  output logic [KEY_BITS-1:0]      fired_key,
  output logic [WORD_W-1:0]        lateness,
  output logic                     last
);

  // entry memory and its port signals
  entry_t             mem [MAX_TASKS];
  entry_t             rd_data;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;

  // control registers
  state_t             state, state_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic               prio, prio_next;
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;
  logic [IDX_W-1:0]   chk_idx, chk_idx_next;
  logic               chk_valid, chk_valid_next;
  logic               stop, stop_next;
  logic               pend_valid, pend_valid_next;
  logic               out_valid_next;

  // payload registers
  logic [2:0]          req_cmd;
  logic [KEY_BITS-1:0] req_key;
  logic [WORD_W-1:0]   req_interval;
  logic                req_enable;
  logic [WORD_W-1:0]   req_now;
  logic [KEY_BITS-1:0] pend_key, pend_key_next;
  logic [WORD_W-1:0]   pend_late, pend_late_next;
  logic [1:0]          status_next;
  logic                fired_next;
  logic [KEY_BITS-1:0] fired_key_next;
  logic [WORD_W-1:0]   lateness_next;
  logic                last_next;

  // datapath helpers
  logic                in_accept;
  logic                can_push;
  logic                is_lookup;
  logic                more;
  logic [WORD_W-1:0]   elapsed;
  logic [WORD_W-1:0]   late_val;
  logic                due;
  logic                fire;
  logic                match;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign can_push  = !out_valid || !out_stall;

  // entry checks on the registered read data
  assign elapsed  = req_now - rd_data.last_run;
  assign late_val = elapsed - rd_data.interval;
  assign due      = (elapsed >= rd_data.interval);
  assign fire     = chk_valid && (rd_data.key != '0) && rd_data.enable && due;
  assign match    = chk_valid && (rd_data.key == req_key);
  assign more     = (rd_idx < entry_count);
  assign is_lookup = (req_cmd == CMD_REGISTER) || (req_cmd == CMD_SET_ENABLE) ||
                     (req_cmd == CMD_SET_INTERVAL);

  // entry memory: registered read, single write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      prio        <= 1'b0;
      rd_idx      <= '0;
      chk_valid   <= 1'b0;
      stop        <= 1'b0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      prio        <= prio_next;
      rd_idx      <= rd_idx_next;
      chk_valid   <= chk_valid_next;
      stop        <= stop_next;
      pend_valid  <= pend_valid_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_cmd      <= command;
      req_key      <= task_key;
      req_interval <= interval_in;
      req_enable   <= enable_in;
      req_now      <= tick_now;
    end
    chk_idx   <= chk_idx_next;
    pend_key  <= pend_key_next;
    pend_late <= pend_late_next;
    status    <= status_next;
    fired     <= fired_next;
    fired_key <= fired_key_next;
    lateness  <= lateness_next;
    last      <= last_next;
  end

  // next state, table walk and result generation
  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    prio_next        = prio;
    rd_idx_next      = rd_idx;
    chk_idx_next     = chk_idx;
    chk_valid_next   = chk_valid;
    stop_next        = stop;
    pend_valid_next  = pend_valid;
    pend_key_next    = pend_key;
    pend_late_next   = pend_late;
    out_valid_next   = out_valid && out_stall;
    status_next      = status;
    fired_next       = fired;
    fired_key_next   = fired_key;
    lateness_next    = lateness;
    last_next        = last;
    mem_re           = 1'b0;
    mem_raddr        = rd_idx[IDX_W-1:0];
    mem_we           = 1'b0;
    mem_waddr        = chk_idx;
    mem_wdata        = rd_data;

    // configuration write
    if (cfg_valid && cfg_ready) begin
      prio_next = priority_mode;
    end

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next      = S_SCAN;
          rd_idx_next     = '0;
          chk_valid_next  = 1'b0;
          stop_next       = 1'b0;
          pend_valid_next = 1'b0;
        end
      end
      S_SCAN: begin
        if (can_push) begin
          if (is_lookup) begin
            // issue the next read while checking the previous entry
            mem_re         = more;
            chk_valid_next = more;
            chk_idx_next   = rd_idx[IDX_W-1:0];
            rd_idx_next    = more ? rd_idx + CNT_W'(1) : rd_idx;
            if (match) begin
              // modify the first matching entry
              mem_we = 1'b1;
              if (req_cmd != CMD_SET_ENABLE) begin
                mem_wdata.interval = req_interval;
              end
              if (req_cmd != CMD_SET_INTERVAL) begin
                mem_wdata.enable = req_enable;
              end
              out_valid_next = 1'b1;
              status_next    = ST_OK;
              fired_next     = 1'b0;
              fired_key_next = '0;
              lateness_next  = '0;
              last_next      = 1'b1;
              state_next     = S_IDLE;
            end else if (!chk_valid && !more) begin
              // key not in the table
              out_valid_next = 1'b1;
              fired_next     = 1'b0;
              fired_key_next = '0;
              lateness_next  = '0;
              last_next      = 1'b1;
              state_next     = S_IDLE;
              if (req_cmd == CMD_REGISTER) begin
                if (entry_count < CNT_W'(MAX_TASKS)) begin
                  // append a new entry
                  mem_we             = 1'b1;
                  mem_waddr          = entry_count[IDX_W-1:0];
                  mem_wdata.key      = req_key;
                  mem_wdata.interval = req_interval;
                  mem_wdata.enable   = req_enable;
                  mem_wdata.last_run = '0;
                  entry_count_next   = entry_count + CNT_W'(1);
                  status_next        = ST_OK;
                end else begin
                  status_next = ST_FULL;
                end
              end else begin
                status_next = ST_NOT_FOUND;
              end
            end
          end else if (req_cmd == CMD_TICK) begin
            // walk the table, holding back one firing to mark the last one
            mem_re         = more && !stop && !(fire && prio);
            chk_valid_next = mem_re;
            chk_idx_next   = rd_idx[IDX_W-1:0];
            rd_idx_next    = mem_re ? rd_idx + CNT_W'(1) : rd_idx;
            if (fire) begin
              mem_we             = 1'b1;
              mem_wdata.last_run = req_now;
              if (prio) begin
                stop_next = 1'b1;
              end
              if (pend_valid) begin
                out_valid_next = 1'b1;
                status_next    = ST_OK;
                fired_next     = 1'b1;
                fired_key_next = pend_key;
                lateness_next  = pend_late;
                last_next      = 1'b0;
              end
              pend_valid_next = 1'b1;
              pend_key_next   = rd_data.key;
              pend_late_next  = late_val;
            end else if (!chk_valid && (stop || !more)) begin
              // end of the walk
              out_valid_next  = 1'b1;
              status_next     = ST_OK;
              fired_next      = pend_valid;
              fired_key_next  = pend_valid ? pend_key : '0;
              lateness_next   = pend_valid ? pend_late : '0;
              last_next       = 1'b1;
              pend_valid_next = 1'b0;
              state_next      = S_IDLE;
            end
          end else begin
            // clear and unused codes
            if (req_cmd == CMD_CLEAR) begin
              entry_count_next = '0;
            end
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            fired_next     = 1'b0;
            fired_key_next = '0;
            lateness_next  = '0;
            last_next      = 1'b1;
            state_next     = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// self-checking testbench for the periodic task dispatcher: directed table, then random phases
module tb_top
  import ptd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // spare request codes that the block ignores
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;

  localparam int RANDOM_PER_PHASE = 28;
  localparam int PHASES           = 5;
  localparam int HOLD_CYCLES      = 400;

  // one expected result
  typedef struct packed {
    logic [1:0]          status;
    logic                fired;
    logic [KEY_BITS-1:0] fkey;
    logic [WORD_W-1:0]   late;
    logic                last;
  } result_t;

  // one row of the directed table; known rows carry a plain expected status
  typedef struct packed {
    logic [2:0]          cmd;
    logic [KEY_BITS-1:0] key;
    logic [WORD_W-1:0]   intv;
    logic                en;
    logic [WORD_W-1:0]   now;
    logic                known;
    logic [1:0]          status;
  } dir_row_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic                priority_mode = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [2:0]          command       = '0;
  logic [KEY_BITS-1:0] task_key      = '0;
  logic [WORD_W-1:0]   interval_in   = '0;
  logic                enable_in     = 1'b0;
  logic [WORD_W-1:0]   tick_now      = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [1:0]          status;
  logic                fired;
  logic [KEY_BITS-1:0] fired_key;
  logic [WORD_W-1:0]   lateness;
  logic                last;

  // predictor copy of the task table and mode
  logic [KEY_BITS-1:0] tbl_key  [MAX_TASKS];
  logic [WORD_W-1:0]   tbl_intv [MAX_TASKS];
  logic                tbl_en   [MAX_TASKS];
  logic [WORD_W-1:0]   tbl_last [MAX_TASKS];
  int                  tbl_count = 0;
  bit                  prio_on   = 1'b0;

  result_t             pending_results[$];
  dir_row_t            directed_rows[$];
  int                  mismatch_count = 0;
  logic [WORD_W-1:0]   clock_ticks    = '0;
  bit                  in_idle_on     = 1'b1;
  bit                  out_idle_on    = 1'b1;
  int                  hold_seq       = 0;
  int                  hold_seen      = 0;
  int                  stall_left     = 0;

  periodic_task_dispatcher uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .priority_mode(priority_mode),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .task_key     (task_key),
    .interval_in  (interval_in),
    .enable_in    (enable_in),
    .tick_now     (tick_now),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .fired        (fired),
    .fired_key    (fired_key),
    .lateness     (lateness),
    .last         (last)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // field compare with report
  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result side: compare accepted results, draw stalls, serve long hold-offs
  always @(posedge clk) begin : result_monitor
    result_t want;
    int      next_stall;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result with nothing pending, key %0h", $time, fired_key);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", WORD_W'(want.status), WORD_W'(status));
          check_field("fired", WORD_W'(want.fired), WORD_W'(fired));
          check_field("fired_key", WORD_W'(want.fkey), WORD_W'(fired_key));
          check_field("lateness", want.late, lateness);
          check_field("last", WORD_W'(want.last), WORD_W'(last));
        end
      end
      next_stall = stall_left;
      if (hold_seen != hold_seq) begin
        hold_seen  <= hold_seq;
        next_stall = HOLD_CYCLES;
      end else if (next_stall != 0) begin
        next_stall--;
      end else if (out_idle_on &&
                   (out_valid || $urandom_range(0, 3) == 0)) begin
        next_stall = $urandom_range(0, 17);
      end
      stall_left <= next_stall;
      out_stall  <= (next_stall != 0);
    end
  end

  // first table entry holding a key, -1 when absent
  function automatic int find_task(logic [KEY_BITS-1:0] key);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  // predict the results of one accepted request and queue them
  task automatic predict_dispatch(logic [2:0] cmd, logic [KEY_BITS-1:0] key,
                                  logic [WORD_W-1:0] intv, logic en,
                                  logic [WORD_W-1:0] now, logic known,
                                  logic [1:0] want_status);
    result_t           r;
    result_t           held;
    bit                have_held;
    logic [WORD_W-1:0] elapsed;
    logic [1:0]        st;
    int                idx;
    st        = ST_OK;
    have_held = 1'b0;
    held      = '0;
    idx       = find_task(key);
    case (cmd)
      CMD_REGISTER: begin
        if (idx >= 0) begin
          tbl_intv[idx] = intv;
          tbl_en[idx]   = en;
        end else if (tbl_count < MAX_TASKS) begin
          tbl_key[tbl_count]  = key;
          tbl_intv[tbl_count] = intv;
          tbl_en[tbl_count]   = en;
          tbl_last[tbl_count] = '0;
          tbl_count++;
        end else begin
          st = ST_FULL;
        end
      end
      CMD_SET_ENABLE: begin
        if (idx >= 0) tbl_en[idx] = en;
        else st = ST_NOT_FOUND;
      end
      CMD_SET_INTERVAL: begin
        if (idx >= 0) tbl_intv[idx] = intv;
        else st = ST_NOT_FOUND;
      end
      CMD_TICK: begin
        // scan in table order; one firing is held back so the final one gets last
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_key[i] != '0 && tbl_en[i]) begin
            elapsed = now - tbl_last[i];
            if (elapsed >= tbl_intv[i]) begin
              tbl_last[i] = now;
              if (have_held && !known) pending_results.push_back(held);
              held       = '0;
              held.fired = 1'b1;
              held.fkey  = tbl_key[i];
              held.late  = elapsed - tbl_intv[i];
              have_held  = 1'b1;
              if (prio_on) break;
            end
          end
        end
      end
      CMD_CLEAR: tbl_count = 0;
      default: ;
    endcase
    if (have_held && !known) begin
      held.last = 1'b1;
      pending_results.push_back(held);
    end else begin
      r        = '0;
      r.status = known ? want_status : st;
      r.last   = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  // offer one request after a random gap and wait for it to be taken
  task automatic send_request(logic [2:0] cmd, logic [KEY_BITS-1:0] key,
                              logic [WORD_W-1:0] intv, logic en,
                              logic [WORD_W-1:0] now, logic known,
                              logic [1:0] want_status);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    task_key    <= key;
    interval_in <= intv;
    enable_in   <= en;
    tick_now    <= now;
    do @(posedge clk); while (in_stall);
    predict_dispatch(cmd, key, intv, en, now, known, want_status);
  endtask

  // random request, biased toward known keys, small intervals and advancing ticks
  task automatic send_random_request();
    int                  pick;
    int                  r;
    logic [2:0]          cmd;
    logic [KEY_BITS-1:0] key;
    logic [WORD_W-1:0]   intv;
    logic                en;
    logic [WORD_W-1:0]   now;
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 99);
    if (r < 80) key = KEY_BITS'($urandom_range(1, 18));
    else if (r < 86) key = '0;
    else if (r < 92) key = '1;
    else key = KEY_BITS'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70) intv = $urandom_range(0, 12);
    else if (r < 80) intv = '0;
    else if (r < 88) intv = $urandom;
    else if (r < 94) intv = '1;
    else intv = $urandom_range(0, 1000);
    en  = ($urandom_range(0, 4) != 0);
    now = $urandom;
    if (pick < 28) cmd = CMD_REGISTER;
    else if (pick < 40) cmd = CMD_SET_ENABLE;
    else if (pick < 50) cmd = CMD_SET_INTERVAL;
    else if (pick < 94) begin
      cmd = CMD_TICK;
      r   = $urandom_range(0, 99);
      if (r < 85) clock_ticks = clock_ticks + $urandom_range(0, 6);
      else if (r < 95) clock_ticks = clock_ticks + $urandom;
      now = clock_ticks;
    end else if (pick < 97) cmd = CMD_CLEAR;
    else cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
    send_request(cmd, key, intv, en, now, 1'b0, ST_OK);
  endtask

  // stop offering, wait for every pending result plus a full scan time
  task automatic drain_dispatcher();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (MAX_TASKS + 4) @(posedge clk);
  endtask

  // write the priority mode register
  task automatic set_priority_mode(bit mode);
    cfg_valid     <= 1'b1;
    priority_mode <= mode;
    do @(posedge clk); while (!cfg_ready);
    prio_on   = mode;
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(logic [2:0] cmd, logic [KEY_BITS-1:0] key,
                                  logic [WORD_W-1:0] intv, logic en,
                                  logic [WORD_W-1:0] now, logic known,
                                  logic [1:0] st);
    dir_row_t row;
    row = '{cmd, key, intv, en, now, known, st};
    directed_rows.push_back(row);
  endfunction

  // main sequence
  initial begin : stimulus
    dir_row_t row;
    // empty table and unknown keys
    add_row(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'd100, 1'b1, ST_OK);
    add_row(CMD_SET_ENABLE, 8'd5, 32'd0, 1'b1, 32'd0, 1'b1, ST_NOT_FOUND);
    add_row(CMD_SET_INTERVAL, 8'd5, 32'd7, 1'b0, 32'd0, 1'b1, ST_NOT_FOUND);
    // key zero is stored but never fires; extremes of key and interval
    add_row(CMD_REGISTER, 8'd0, 32'd0, 1'b1, 32'd0, 1'b1, ST_OK);
    add_row(CMD_REGISTER, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1, ST_OK);
    add_row(CMD_REGISTER, 8'd1, 32'd0, 1'b1, 32'd0, 1'b1, ST_OK);
    add_row(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'd0, 1'b0, ST_OK);
    add_row(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b0, ST_OK);
    // update of an existing key keeps its last run
    add_row(CMD_REGISTER, 8'd1, 32'd10, 1'b0, 32'd0, 1'b1, ST_OK);
    add_row(CMD_SET_ENABLE, 8'd1, 32'd0, 1'b1, 32'd0, 1'b1, ST_OK);
    add_row(CMD_SET_INTERVAL, 8'd1, 32'd5, 1'b0, 32'd0, 1'b1, ST_OK);
    // elapsed time across the wrap
    add_row(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'd3, 1'b0, ST_OK);
    add_row(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'd4, 1'b0, ST_OK);
    add_row(CMD_SET_ENABLE, 8'd1, 32'd0, 1'b0, 32'd0, 1'b1, ST_OK);
    add_row(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'h8000_0000, 1'b0, ST_OK);
    // ignored codes
    add_row(CMD_SPARE_A, 8'hAA, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA, 1'b1, ST_OK);
    add_row(CMD_SPARE_B, 8'h55, 32'hAAAA_AAAA, 1'b0, 32'h5555_5555, 1'b1, ST_OK);
    add_row(CMD_SPARE_C, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, ST_OK);
    // clear empties the table
    add_row(CMD_CLEAR, 8'd0, 32'd0, 1'b0, 32'd0, 1'b1, ST_OK);
    add_row(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'hFFFF_FFFF, 1'b1, ST_OK);
    add_row(CMD_SET_INTERVAL, 8'hFF, 32'd1, 1'b0, 32'd0, 1'b1, ST_NOT_FOUND);
    add_row(CMD_REGISTER, 8'd7, 32'd1, 1'b1, 32'd0, 1'b1, ST_OK);
    add_row(CMD_TICK, 8'd0, 32'd0, 1'b0, 32'd1, 1'b0, ST_OK);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_priority_mode(1'b0);
    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      send_request(row.cmd, row.key, row.intv, row.en, row.now, row.known, row.status);
    end
    drain_dispatcher();

    // random phases alternating the mode; one without idling, one under back-pressure
    for (int phase = 0; phase < PHASES; phase++) begin
      in_idle_on  = (phase != 2);
      out_idle_on = (phase != 2);
      set_priority_mode(phase % 2 == 0);
      clock_ticks = (phase == 1) ? 32'hFFFF_FFC0 : $urandom;
      if (phase == 3) begin
        in_idle_on = 1'b0;
        hold_seq   <= hold_seq + 1;
      end
      // fill the table, then overflow it
      send_request(CMD_CLEAR, 8'd0, 32'd0, 1'b0, $urandom, 1'b0, ST_OK);
      for (int k = 1; k <= MAX_TASKS; k++) begin
        send_request(CMD_REGISTER, 8'(k), $urandom_range(0, 8),
                     ($urandom_range(0, 5) != 0), $urandom, 1'b0, ST_OK);
      end
      send_request(CMD_REGISTER, 8'd200, $urandom, 1'b1, $urandom, 1'b0, ST_OK);
      in_idle_on = (phase != 2);
      repeat (RANDOM_PER_PHASE) send_random_request();
      drain_dispatcher();
    end

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
hdl/ptd_pkg.sv
hdl/periodic_task_dispatcher.sv
sim/tb_top.sv
